// File: src/rag_pkg.sv
`default_nettype none
package rag_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int WIDE_WIDTH = 64;
  localparam int CNT_WIDTH = 7;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_FIT,
    ST_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic mul;
    logic sum;
    logic gcd_step;
    logic div_start_num;
    logic div_start_den;
    logic div_step;
    logic div_save_num;
    logic fit;
    logic cmp;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic zero_den;
    logic do_update;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

// File: src/rag_if.sv
`default_nettype none
interface rag_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic signed [31:0] operand_num;
  logic signed [31:0] operand_den;
  modport source (output valid, func, operand_num, operand_den, input ready);
  modport sink (input valid, func, operand_num, operand_den, output ready);
endinterface

interface rag_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value_num;
  logic [30:0] value_den;
  logic        is_equal;
  logic        is_less;
  logic        is_nonzero;
  logic [1:0]  error;
  modport source (output valid, value_num, value_den, is_equal, is_less, is_nonzero,
                  error, input ready);
  modport sink (input valid, value_num, value_den, is_equal, is_less, is_nonzero,
                error, output ready);
endinterface
`default_nettype wire

// File: src/rag_datapath.sv
`default_nettype none
module rag_datapath
  import rag_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_num,
  input  wire logic signed [31:0] in_den,
  output logic signed [31:0]      o_num,
  output logic [30:0]             o_den,
  output logic                    o_eq,
  output logic                    o_lt,
  output logic                    o_nz,
  output logic [1:0]              o_err
);

  localparam logic signed [63:0] HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;

  logic [1:0]         func;
  logic signed [63:0] c, d;
  logic signed [31:0] acc_num;
  logic [30:0]        acc_den;
  logic signed [63:0] p1, p2, p3;
  logic signed [63:0] sn, sd;
  logic [63:0]        ga, gb;
  logic [CNT_WIDTH-1:0] gk;
  logic [63:0]        dvd, dvs, quo, rem, qn;
  logic [CNT_WIDTH-1:0] cnt;
  logic [1:0]         err;
  logic               eq, lt;
  logic [64:0]        trial;
  logic               fit_ok;
  logic signed [32:0] acc_num_x, acc_den_x, c_x, d_x;
  logic signed [65:0] m1, m2, m3;

  // After the sign fix the operand fits 33 signed bits, so the products stay narrow.
  assign acc_num_x = {acc_num[31], acc_num};
  assign acc_den_x = {2'b00, acc_den};
  assign c_x = c[32:0];
  assign d_x = d[32:0];
  assign m1 = acc_num_x * d_x;
  assign m2 = c_x * acc_den_x;
  assign m3 = acc_den_x * d_x;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem[63:0], dvd[63]} - {1'b0, dvs};

  assign fit_ok = !(sn < 0 ? (qn > 64'(HI) + 64'd1) : (qn > 64'(HI)))
                  && !(quo > 64'(HI) || quo == 64'd0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= in_func;
      c <= 64'(in_num);
      d <= 64'(in_den);
      err <= ERR_NONE;
    end
    if (cmd.prep) begin
      if (d < 0) begin
        d <= -d;
        c <= -c;
      end
      if (d == 0) begin
        err <= ERR_ZERO_DEN;
      end
    end
    if (cmd.mul) begin
      p1 <= m1[63:0];
      p2 <= m2[63:0];
      p3 <= m3[63:0];
    end
    if (cmd.sum) begin
      gk <= '0;
      if (func == FUNC_LOAD) begin
        sn <= c;
        sd <= d;
        ga <= 64'(d);
        gb <= c < 0 ? 64'(-c) : 64'(c);
      end else begin
        sn <= p1 + p2;
        sd <= p3;
        ga <= 64'(p3);
        gb <= (p1 + p2) < 0 ? 64'(-(p1 + p2)) : 64'(p1 + p2);
      end
    end
    // Binary gcd: common factors of two are counted in gk and restored at the end.
    if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        gk <= gk + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga > gb) begin
        ga <= (ga - gb) >> 1;
      end else begin
        gb <= (gb - ga) >> 1;
      end
    end
    if (cmd.div_start_num || cmd.div_start_den) begin
      dvd <= cmd.div_start_num ? (sn < 0 ? 64'(-sn) : 64'(sn)) : 64'(sd);
      dvs <= ga << gk;
      rem <= 64'd0;
      quo <= 64'd0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
      cnt <= cnt + 1'b1;
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], dvd[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
    if (cmd.div_save_num) begin
      qn <= quo;
    end
    if (cmd.fit && !fit_ok) begin
      err <= ERR_OVERFLOW;
    end
    if (cmd.cmp) begin
      eq <= (err != ERR_ZERO_DEN) && (p1 == p2);
      lt <= (err != ERR_ZERO_DEN) && (p1 < p2);
    end
    if (cmd.load_out) begin
      o_num <= acc_num;
      o_den <= acc_den;
      o_eq <= eq;
      o_lt <= lt;
      o_nz <= acc_num != 32'sd0;
      o_err <= err;
    end
  end

  // Held value: reset to 0/1, and loaded with the reduced fraction when a fit succeeds.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= '0;
      acc_den <= 31'd1;
    end else if (cmd.fit && fit_ok) begin
      acc_num <= sn < 0 ? 32'(-qn) : 32'(qn);
      acc_den <= 31'(quo);
    end
  end

  always_comb begin
    status.zero_den = (err == ERR_ZERO_DEN);
    status.do_update = (func == FUNC_LOAD) || (func == FUNC_ADD);
    status.gcd_done = (gb == 64'd0);
    status.div_done = (cnt == CNT_WIDTH'(WIDE_WIDTH));
  end

endmodule
`default_nettype wire

// File: src/rag_ctrl.sv
`default_nettype none
module rag_ctrl
  import rag_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;
  logic   div_den, div_den_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      div_den <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      div_den <= div_den_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    div_den_next = div_den;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (status.zero_den || !status.do_update) begin
          state_next = ST_CMP;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = ST_GCD;
      end
      ST_GCD: begin
        if (status.gcd_done) begin
          cmd.div_start_num = 1'b1;
          div_den_next = 1'b0;
          state_next = ST_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIVN: begin
        if (status.div_done) begin
          cmd.div_save_num = 1'b1;
          cmd.div_start_den = 1'b1;
          state_next = ST_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DIVD: begin
        if (status.div_done) begin
          state_next = ST_FIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIT: begin
        cmd.fit = 1'b1;
        div_den_next = 1'b1;
        state_next = ST_PREP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          div_den_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // After a fit the products are formed again against the new value.
    if (state == ST_MUL && div_den) begin
      state_next = ST_CMP;
    end
  end

  a_cmd_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state == ST_IDLE) else $error("capture outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_load_after_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> $past(state) == ST_CMP || $past(state) == ST_OUT)
    else $error("result without compare");

endmodule
`default_nettype wire

// File: src/rational_accumulator_gcd.sv
`default_nettype none
// Rational accumulator: holds one reduced fraction and, for each item, loads, adds or
// compares an operand, returning one result item. A load or add runs a binary gcd, then
// two 64-step restoring divisions that reduce numerator and denominator, and a second
// product pass forms the flags against the new value. Compare-only and zero-denominator
// items skip the gcd and the divisions. Input is taken only while the block is idle;
// one result waits in the output register.
module rational_accumulator_gcd
  import rag_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  rag_in_if.sink   in_ch,
  rag_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  rag_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  rag_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_func(in_ch.func), .in_num(in_ch.operand_num), .in_den(in_ch.operand_den),
    .o_num(out_ch.value_num), .o_den(out_ch.value_den), .o_eq(out_ch.is_equal),
    .o_lt(out_ch.is_less), .o_nz(out_ch.is_nonzero), .o_err(out_ch.error)
  );

endmodule
`default_nettype wire

// File: sim/tb_rational_accumulator_gcd.sv
`timescale 1ns / 100ps
module tb_rational_accumulator_gcd;
  import rag_pkg::*;

  localparam logic [1:0] FUNC_CMP = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic signed [31:0] onum;
    logic signed [31:0] oden;
  } op_item_t;

  typedef struct packed {
    logic signed [31:0] vnum;
    logic [30:0] vden;
    logic eq;
    logic lt;
    logic nz;
    logic [1:0] err;
  } sum_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rag_in_if in_ch ();
  rag_out_if out_ch ();

  rational_accumulator_gcd dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  op_item_t pending_ops[$];
  sum_item_t expected_sums[$];
  longint acc_n = 0;
  longint acc_d = 1;
  int mismatches = 0;
  bit stimulus_done = 0;
  bit calm = 0;
  bit hold_start = 0;
  bit hold_used = 0;
  int hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int sent_count = 0;
  int taken_count = 0;

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit reduce_fit(longint n, longint d, output longint rn, output longint rd);
    longint unsigned mn, g, qn, qd;
    longint hi;
    mn = (n < 0) ? longint'(-n) : longint'(n);
    hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
    g = gcd64(longint'(d), mn);
    rn = 0;
    rd = 1;
    if (g == 0) return 0;
    qn = mn / g;
    qd = longint'(d) / g;
    if (qd > hi || qd == 0) return 0;
    if (n < 0) begin
      if (qn > hi + 1) return 0;
      rn = -longint'(qn);
    end else begin
      if (qn > hi) return 0;
      rn = qn;
    end
    rd = qd;
    return 1;
  endfunction

  function automatic sum_item_t predict_sum(op_item_t it);
    sum_item_t r;
    longint c, d, rn, rd, sn, sd, lhs, rhs;
    r = '0;
    c = longint'(it.onum);
    d = longint'(it.oden);
    if (d == 0) begin
      r.err = ERR_ZERO_DEN;
    end else begin
      if (d < 0) begin
        d = -d;
        c = -c;
      end
      if (it.func == FUNC_LOAD) begin
        if (reduce_fit(c, d, rn, rd)) begin
          acc_n = rn;
          acc_d = rd;
        end else r.err = ERR_OVERFLOW;
      end else if (it.func == FUNC_ADD) begin
        sn = acc_n * d + c * acc_d;
        sd = acc_d * d;
        if (reduce_fit(sn, sd, rn, rd)) begin
          acc_n = rn;
          acc_d = rd;
        end else r.err = ERR_OVERFLOW;
      end
      lhs = acc_n * d;
      rhs = c * acc_d;
      r.eq = (lhs == rhs);
      r.lt = (lhs < rhs);
    end
    r.vnum = acc_n[31:0];
    r.vden = acc_d[30:0];
    r.nz = (acc_n != 0);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 20)) - 10;
      1: return 32'sh7fffffff - $urandom_range(0, 2);
      2: return 32'sh80000000 + $urandom_range(0, 2);
      3: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic [1:0] f, logic signed [31:0] n, logic signed [31:0] d);
    op_item_t it;
    it.func = f;
    it.onum = n;
    it.oden = d;
    pending_ops.push_back(it);
  endtask

  // Input monitor: the predictor runs at the moment an item is accepted.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      op_item_t it;
      it.func = in_ch.func;
      it.onum = in_ch.operand_num;
      it.oden = in_ch.operand_den;
      expected_sums.push_back(predict_sum(it));
      taken_count = taken_count + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && taken_count != sent_count) begin
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      send_gap <= $urandom_range(1, 10) - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_ops.size() > 0) begin
      op_item_t it;
      it = pending_ops.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.func <= it.func;
      in_ch.operand_num <= it.onum;
      in_ch.operand_den <= it.oden;
      sent_count <= sent_count + 1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_start && !hold_used) begin
      hold_used <= 1'b1;
      hold_off <= 3000;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(1, 10) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sum_item_t got, want;
      got.vnum = out_ch.value_num;
      got.vden = out_ch.value_den;
      got.eq = out_ch.is_equal;
      got.lt = out_ch.is_less;
      got.nz = out_ch.is_nonzero;
      got.err = out_ch.error;
      if (expected_sums.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_sums.pop_front();
        if (got !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.operand_num = '0;
    in_ch.operand_den = 32'sd1;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_op(FUNC_CMP, 0, 1);
    push_op(FUNC_LOAD, 6, -4);
    push_op(FUNC_ADD, 1, 2);
    push_op(FUNC_LOAD, 32'sh7fffffff, 1);
    push_op(FUNC_ADD, 1, 1);
    push_op(FUNC_LOAD, 32'sh80000000, 1);
    push_op(FUNC_LOAD, 32'sh80000000, -1);
    push_op(FUNC_LOAD, 1, 32'sh80000000);
    push_op(FUNC_LOAD, 1, 32'sh7fffffff);
    push_op(FUNC_ADD, 1, 32'sh7ffffffe);
    push_op(FUNC_ADD, 5, 0);
    push_op(FUNC_CMP, -3, -7);
    push_op(FUNC_SPARE, 1, 3);
    push_op(FUNC_LOAD, -9, 12);
    push_op(FUNC_ADD, 9, 12);
    push_op(FUNC_CMP, 0, 5);
    push_op(FUNC_LOAD, 32'sh80000000, 32'sh80000000);
    push_op(FUNC_SPARE, 32'sh7fffffff, 32'sh80000000);
    push_op(FUNC_ADD, -1, 1);

    for (int i = 0; i < 900; i++) begin
      logic [1:0] f;
      logic signed [31:0] d;
      f = 2'($urandom_range(0, 9) < 4 ? FUNC_ADD : $urandom_range(0, 3));
      d = ($urandom_range(0, 19) == 0) ? 0 : rand_field();
      push_op(f, rand_field(), d);
      if (i == 300) begin
        while (pending_ops.size() > 0) @(posedge clk);
        hold_start = 1;
      end
      if (i == 750) begin
        while (pending_ops.size() > 0) @(posedge clk);
        calm = 1;
      end
    end
    while (pending_ops.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_sums.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
